// File: rtl/screen_ownership_handover_fsm_assert.svh
// Assertion macros shared by the display ownership handover RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef SCREEN_OWNERSHIP_HANDOVER_FSM_ASSERT_SVH
`define SCREEN_OWNERSHIP_HANDOVER_FSM_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SOH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("handover assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SOH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("handover assertion failed");

`endif

// File: rtl/soh_pkg.sv
// Package for the display ownership handover block: codes, widths, run word.
// No dependencies; imported by every module of the block.
package soh_pkg;

    localparam int TIME_W      = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_RESULTS = 3;
    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd2000;

    typedef enum logic [1:0] {
        OP_VISIBILITY = 2'd0,
        OP_SESSION    = 2'd1,
        OP_OWNER      = 2'd2,
        OP_TICK       = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        OWNER_NONE       = 2'd0,
        OWNER_ACCESSORY  = 2'd1,
        OWNER_CONTROLLER = 2'd2,
        OWNER_UNKNOWN    = 2'd3
    } t_owner;

    typedef enum logic [2:0] {
        KIND_TAKE      = 3'd0,
        KIND_UNTAKE    = 3'd1,
        KIND_UI        = 3'd2,
        KIND_KEYFRAME  = 3'd3,
        KIND_RELEASED  = 3'd4,
        KIND_REQUESTED = 3'd5
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE  = 2'd0,
        CFG_UI_SHOW = 2'd1,
        CFG_TIMEOUT = 2'd2
    } t_cfg_idx;

    // One queued run: the results caused by one event, in order.
    typedef struct packed {
        logic [1:0]            count;
        t_kind [MAX_RESULTS-1:0] kinds;
    } t_run;

endpackage

// File: rtl/soh_front.sv
// Front part: holds the configuration and handover state, classifies each
// event and builds its run of results. Depends on soh_pkg.
module soh_front
    import soh_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_opcode,
    input  logic                  i_flag,
    input  logic [1:0]            i_owner,
    input  logic [TIME_W-1:0]     i_time,
    input  logic                  i_full,
    output logic                  o_push,
    output t_run                  o_run
);

`include "screen_ownership_handover_fsm_assert.svh"

    logic              r_enable, r_ui_show;
    logic [TIME_W-1:0] r_timeout;
    logic              r_shown, r_gave, r_holding, r_wait, r_session, r_heard;
    logic [1:0]        r_owner;
    logic [TIME_W-1:0] r_htime;

    logic              n_shown, n_gave, n_holding, n_wait, n_session, n_heard;
    logic [1:0]        n_owner;
    logic [TIME_W-1:0] n_htime;
    logic [TIME_W-1:0] elapsed;
    logic              do_rec, want, accept;
    t_run              n_run;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign elapsed = i_time - r_htime;

    // Work out the next state and the run of results for this event
    always_comb begin
        n_shown   = r_shown;
        n_gave    = r_gave;
        n_holding = r_holding;
        n_wait    = r_wait;
        n_session = r_session;
        n_heard   = r_heard;
        n_owner   = r_owner;
        n_htime   = r_htime;
        do_rec    = 1'b0;
        want      = 1'b0;
        n_run.count    = 2'd0;
        n_run.kinds[0] = KIND_TAKE;
        n_run.kinds[1] = KIND_TAKE;
        n_run.kinds[2] = KIND_TAKE;

        case (i_opcode)
            OP_VISIBILITY: begin
                n_heard = 1'b1;
                n_htime = i_time;
                if (i_flag != r_shown) begin
                    n_shown = i_flag;
                    if (i_flag) begin
                        n_gave = 1'b0;
                    end
                    do_rec = 1'b1;
                end
            end
            OP_SESSION: begin
                if (i_flag) begin
                    if (!r_session) begin
                        n_session = 1'b1;
                        do_rec    = 1'b1;
                    end
                end else begin
                    n_session = 1'b0;
                    n_holding = 1'b0;
                    n_wait    = 1'b0;
                    n_gave    = 1'b0;
                    n_owner   = OWNER_UNKNOWN;
                end
            end
            OP_OWNER: begin
                n_owner = i_owner;
                if (r_enable && r_session) begin
                    if (i_owner == OWNER_ACCESSORY) begin
                        if (r_wait) begin
                            n_wait = 1'b0;
                        end else if (!r_shown && !r_holding && r_owner == OWNER_CONTROLLER) begin
                            n_holding      = 1'b1;
                            n_gave         = 1'b0;
                            n_run.kinds[0] = KIND_RELEASED;
                            n_run.count    = 2'd1;
                        end
                    end else if (i_owner == OWNER_CONTROLLER) begin
                        if (r_wait) begin
                            n_holding = 1'b0;
                            n_wait    = 1'b0;
                            n_gave    = 1'b1;
                        end else if (r_holding) begin
                            n_holding = 1'b0;
                            n_gave    = 1'b1;
                            if (!r_shown) begin
                                n_run.kinds[0] = KIND_REQUESTED;
                                n_run.count    = 2'd1;
                            end
                        end
                    end
                end
            end
            default: begin
                // Timer tick: a display with no recent report counts as visible
                if (r_heard && !r_shown && (elapsed > r_timeout)) begin
                    n_shown = 1'b1;
                    n_gave  = 1'b0;
                    do_rec  = 1'b1;
                end
            end
        endcase

        // Reconcile ownership with what the block wants
        if (do_rec && r_enable && n_session) begin
            want = !n_shown && !n_gave;
            if (want && !n_holding) begin
                n_run.kinds[0] = KIND_TAKE;
                n_run.count    = 2'd1;
                n_holding      = 1'b1;
                n_wait         = 1'b1;
            end else if (!want && n_holding) begin
                n_run.kinds[0] = KIND_UNTAKE;
                if (r_ui_show) begin
                    n_run.kinds[1] = KIND_UI;
                    n_run.kinds[2] = KIND_KEYFRAME;
                    n_run.count    = 2'd3;
                end else begin
                    n_run.kinds[1] = KIND_KEYFRAME;
                    n_run.count    = 2'd2;
                end
                n_holding = 1'b0;
                n_wait    = 1'b0;
            end
        end
    end

    assign o_push = accept && (n_run.count != 2'd0);
    assign o_run  = n_run;

    // Take configuration writes; ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b1;
            r_ui_show <= 1'b1;
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ENABLE:  r_enable  <= i_cfg_wdata[0];
                CFG_UI_SHOW: r_ui_show <= i_cfg_wdata[0];
                CFG_TIMEOUT: r_timeout <= i_cfg_wdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the handover state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown   <= 1'b0;
            r_gave    <= 1'b0;
            r_holding <= 1'b0;
            r_wait    <= 1'b0;
            r_session <= 1'b0;
            r_heard   <= 1'b0;
            r_owner   <= OWNER_UNKNOWN;
            r_htime   <= '0;
        end else if (accept) begin
            r_shown   <= n_shown;
            r_gave    <= n_gave;
            r_holding <= n_holding;
            r_wait    <= n_wait;
            r_session <= n_session;
            r_heard   <= n_heard;
            r_owner   <= n_owner;
            r_htime   <= n_htime;
        end
    end

    // Holding needs a live session; awaiting acknowledgement needs holding
    `SOH_ASSERT_NOW(a_hold_needs_session, i_clk, i_rst_n, r_holding, r_session)
    `SOH_ASSERT_NOW(a_wait_needs_hold, i_clk, i_rst_n, r_wait, r_holding)

endmodule

// File: rtl/soh_fifo.sv
// Short queue of result runs between the front and back parts.
// Depends on soh_pkg for the run word.
module soh_fifo
    import soh_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_run i_wdata,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_run o_head
);

`include "screen_ownership_handover_fsm_assert.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_run             r_mem [DEPTH];
    t_run             r_head;
    logic [PTR_W-1:0] r_wptr, r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_head  = r_head;
    assign n_rptr  = i_pop ? ((r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1) : r_rptr;

    // Store pushed runs; register the next head, bypassing a run that lands there
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
        if (i_push && (n_rptr == r_wptr)) begin
            r_head <= i_wdata;
        end else begin
            r_head <= r_mem[n_rptr];
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            r_rptr <= n_rptr;
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `SOH_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push, !o_full || i_pop)
    `SOH_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid)

endmodule

// File: rtl/soh_back.sv
// Back part: walks the run at the queue head and hands out one result
// word per cycle while tready is high, marking the last of each run. Depends on soh_pkg.
module soh_back
    import soh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_run       i_head,
    output logic       o_pop,
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [7:0] o_tdata,
    output logic       o_tlast
);

`include "screen_ownership_handover_fsm_assert.svh"

    logic [1:0] r_idx, n_idx;
    logic       last;

    assign last     = (r_idx == (i_head.count - 2'd1));
    assign o_tvalid = i_valid;
    assign o_tdata  = {5'd0, i_head.kinds[r_idx]};
    assign o_tlast  = last;
    assign o_pop    = o_tvalid && i_tready && last;

    // Step through the run; restart at the head of the next one
    always_comb begin
        n_idx = r_idx;
        if (o_tvalid && i_tready) begin
            n_idx = last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else begin
            r_idx <= n_idx;
        end
    end

    // A queued run is never empty and the index stays inside it
    `SOH_ASSERT_NOW(a_idx_in_run, i_clk, i_rst_n, o_tvalid,
        (i_head.count != 2'd0) && (r_idx < i_head.count))

endmodule

// File: rtl/screen_ownership_handover_fsm.sv
// Top level of the display ownership handover controller.
// Depends on soh_pkg, soh_front, soh_fifo and soh_back.
//
// Usage:
//  - Slave stream carries events: tuser holds the opcode (visibility report,
//    session change, owner report, timer tick); tdata holds flag, owner code
//    and the millisecond time stamp.
//  - Master stream carries result words: tdata holds the result kind, tlast
//    marks the last result caused by one event. Events with no result give
//    no word at all.
//  - Configuration is a plain write port (enable, index, data); write it only
//    while no results are pending.
//  - The run of each accepted event is registered in the run queue; its first
//    result is offered once the runs ahead of it have left. Events are accepted
//    one per cycle while the run queue (QUEUE_DEPTH runs) has room; results
//    leave one per cycle while the receiver is ready.
//  - A stalled receiver holds the current word; events keep entering until
//    the run queue fills, then tready drops.
//  - Reset (synchronous, active low) clears the queue and all handover state
//    and restores the configuration defaults.
module screen_ownership_handover_fsm
    import soh_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata: [0] flag_value, [2:1] owner_code, [34:3] time_ms, [39:35] zero
    input  logic [39:0]           i_s_axis_tdata,
    // tuser: [1:0] opcode
    input  logic [1:0]            i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata: [2:0] result_kind, [7:3] zero
    output logic [7:0]            o_m_axis_tdata,
    output logic                  o_m_axis_tlast
);

    logic push, full, pop, qvalid;
    t_run push_run, head_run;

    soh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_opcode    (i_s_axis_tuser),
        .i_flag      (i_s_axis_tdata[0]),
        .i_owner     (i_s_axis_tdata[2:1]),
        .i_time      (i_s_axis_tdata[TIME_W+2:3]),
        .i_full      (full),
        .o_push      (push),
        .o_run       (push_run)
    );

    soh_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_run),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (qvalid),
        .o_head  (head_run)
    );

    soh_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (qvalid),
        .i_head   (head_run),
        .o_pop    (pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

endmodule

// File: dv/tb_screen_ownership_handover_fsm.sv
// Self-checking testbench for screen_ownership_handover_fsm: a directed table, then random
// event mixes under several register settings, checked word by word against a local predictor.
// Depends on soh_pkg and the RTL of the block only.
module tb_screen_ownership_handover_fsm;
    import soh_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // outside the register map
    localparam int N_ROWS      = 25;
    localparam int N_PHASES    = 5;
    localparam int PHASE_ITEMS = 16;
    localparam int TOTAL_ITEMS = 130;
    localparam int DRAIN_LIMIT = 5000;
    localparam int HOLD_CYCLES = 60;

    typedef struct packed {
        t_kind kind;
        logic  last;
    } t_result_word;

    typedef struct {
        t_op               op;
        logic              flag;
        logic [1:0]        owner;
        logic [TIME_W-1:0] stamp;
        bit                typed;
        int                n;
        t_kind             k0;
        t_kind             k1;
        t_kind             k2;
    } t_stim_row;

    typedef struct {
        logic              enable;
        logic              ui_show;
        logic [TIME_W-1:0] timeout;
    } t_reg_set;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // tdata: [0] flag_value, [2:1] owner_code, [34:3] time_ms, [39:35] zero
    logic [39:0]           i_s_axis_tdata = '0;
    // tuser: [1:0] opcode
    logic [1:0]            i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // tdata: [2:0] result_kind, [7:3] zero
    logic [7:0]            o_m_axis_tdata;
    logic                  o_m_axis_tlast;

    // Tags of the directed row on the bus, aligned with tdata
    bit    row_typed = 1'b0;
    int    row_n = 0;
    t_kind row_k0 = KIND_TAKE;
    t_kind row_k1 = KIND_TAKE;
    t_kind row_k2 = KIND_TAKE;

    // Predictor state and register copy, at reset values
    logic              en_handover    = 1'b1;
    logic              en_ui_request  = 1'b1;
    logic [TIME_W-1:0] stale_limit    = TIMEOUT_RESET;
    logic              disp_visible   = 1'b0;
    logic              yielded        = 1'b0;
    logic              holding        = 1'b0;
    logic              awaiting_ack   = 1'b0;
    logic              session_active = 1'b0;
    logic              heard_any      = 1'b0;
    logic [1:0]        owner_seen     = OWNER_UNKNOWN;
    logic [TIME_W-1:0] heard_ms       = '0;

    t_kind        run_kinds[$];
    t_result_word expected_words[$];
    int           mismatches = 0;
    int           burst_left = 0;
    logic [TIME_W-1:0] wall_ms = 32'hFFFF_F000;  // crosses the wrap early in the run

    logic hold_req = 1'b0;
    int   hold_cnt = 0;
    int   rx_mode = 0;
    int   rx_mode_left = 0;

    t_stim_row script [N_ROWS] = '{
        // after reset: tick before any visibility report does nothing
        '{OP_TICK,       1'b1, OWNER_CONTROLLER, 32'hFFFF_FFFF, 1, 0,
          KIND_TAKE, KIND_TAKE, KIND_TAKE},
        '{OP_OWNER,      1'b0, OWNER_ACCESSORY,  32'h0000_0000, 1, 0,
          KIND_TAKE, KIND_TAKE, KIND_TAKE},
        '{OP_SESSION,    1'b1, OWNER_NONE,       32'h0000_0000, 1, 1,
          KIND_TAKE, KIND_TAKE, KIND_TAKE},
        '{OP_SESSION,    1'b1, OWNER_UNKNOWN,    32'hFFFF_FFFF, 1, 0,
          KIND_TAKE, KIND_TAKE, KIND_TAKE},
        '{OP_OWNER,      1'b1, OWNER_ACCESSORY,  32'h0000_0000, 0, 0,
          KIND_TAKE, KIND_TAKE, KIND_TAKE},
        '{OP_OWNER,      1'b0, OWNER_CONTROLLER, 32'h0000_0000, 0, 0,
          KIND_TAKE, KIND_TAKE, KIND_TAKE},
        '{OP_OWNER,      1'b0, OWNER_ACCESSORY,  32'hFFFF_FFFF, 0, 0,
          KIND_TAKE, KIND_TAKE, KIND_TAKE},
        '{OP_VISIBILITY, 1'b1, OWNER_NONE,       32'h0000_0000, 0, 0,
          KIND_TAKE, KIND_TAKE, KIND_TAKE},
        // repeated visibility value at the top of the time range
        '{OP_VISIBILITY, 1'b1, OWNER_CONTROLLER, 32'hFFFF_FFFF, 1, 0,
          KIND_TAKE, KIND_TAKE, KIND_TAKE},
        '{OP_VISIBILITY, 1'b0, OWNER_NONE,       32'd100,       0, 0,
          KIND_TAKE, KIND_TAKE, KIND_TAKE},
        '{OP_OWNER,      1'b0, OWNER_CONTROLLER, 32'h0000_0000, 0, 0,
          KIND_TAKE, KIND_TAKE, KIND_TAKE},
        // age equal to the timeout, then one past it
        '{OP_TICK,       1'b0, OWNER_NONE,       32'd2100,      0, 0,
          KIND_TAKE, KIND_TAKE, KIND_TAKE},
        '{OP_TICK,       1'b0, OWNER_NONE,       32'd2101,      0, 0,
          KIND_TAKE, KIND_TAKE, KIND_TAKE},
        '{OP_VISIBILITY, 1'b0, OWNER_ACCESSORY,  32'hFFFF_FF00, 0, 0,
          KIND_TAKE, KIND_TAKE, KIND_TAKE},
        // age measured across the 32-bit wrap
        '{OP_TICK,       1'b1, OWNER_UNKNOWN,    32'h0000_0800, 0, 0,
          KIND_TAKE, KIND_TAKE, KIND_TAKE},
        // unused owner code only records "no owner known"
        '{OP_OWNER,      1'b1, OWNER_UNKNOWN,    32'hFFFF_FFFF, 1, 0,
          KIND_TAKE, KIND_TAKE, KIND_TAKE},
        '{OP_OWNER,      1'b1, OWNER_NONE,       32'hFFFF_FFFF, 1, 0,
          KIND_TAKE, KIND_TAKE, KIND_TAKE},
        '{OP_SESSION,    1'b0, OWNER_UNKNOWN,    32'hFFFF_FFFF, 1, 0,
          KIND_TAKE, KIND_TAKE, KIND_TAKE},
        '{OP_TICK,       1'b1, OWNER_UNKNOWN,    32'h0000_0000, 0, 0,
          KIND_TAKE, KIND_TAKE, KIND_TAKE},
        '{OP_VISIBILITY, 1'b0, OWNER_CONTROLLER, 32'd5,         0, 0,
          KIND_TAKE, KIND_TAKE, KIND_TAKE},
        '{OP_SESSION,    1'b1, OWNER_ACCESSORY,  32'h0000_0000, 0, 0,
          KIND_TAKE, KIND_TAKE, KIND_TAKE},
        '{OP_OWNER,      1'b0, OWNER_CONTROLLER, 32'hFFFF_FFFF, 0, 0,
          KIND_TAKE, KIND_TAKE, KIND_TAKE},
        '{OP_OWNER,      1'b1, OWNER_ACCESSORY,  32'h0000_0000, 0, 0,
          KIND_TAKE, KIND_TAKE, KIND_TAKE},
        '{OP_VISIBILITY, 1'b1, OWNER_UNKNOWN,    32'hFFFF_FFFF, 0, 0,
          KIND_TAKE, KIND_TAKE, KIND_TAKE},
        '{OP_SESSION,    1'b0, OWNER_NONE,       32'h0000_0000, 1, 0,
          KIND_TAKE, KIND_TAKE, KIND_TAKE}
    };

    t_reg_set phases [N_PHASES] = '{
        '{1'b1, 1'b1, TIMEOUT_RESET},
        '{1'b1, 1'b0, 32'd0},
        '{1'b0, 1'b1, 32'd300},
        '{1'b1, 1'b1, 32'hFFFF_FFFF},
        '{1'b1, 1'b0, 32'd50}
    };

    screen_ownership_handover_fsm u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Append one result kind to the run of the current event
    function automatic void add_kind(t_kind k);
        run_kinds.insert(run_kinds.size(), k);
    endfunction

    // Append one expected result word
    function automatic void add_word(t_kind k, logic last_flag);
        t_result_word w;
        w.kind = k;
        w.last = last_flag;
        expected_words.insert(expected_words.size(), w);
    endfunction

    // Follow the wish for the screen: take it or hand it back
    function automatic void follow_wish();
        logic want;
        if (!en_handover || !session_active) return;
        want = !disp_visible && !yielded;
        if (want && !holding) begin
            add_kind(KIND_TAKE);
            holding = 1'b1;
            awaiting_ack = 1'b1;
        end else if (!want && holding) begin
            add_kind(KIND_UNTAKE);
            if (en_ui_request) add_kind(KIND_UI);
            add_kind(KIND_KEYFRAME);
            holding = 1'b0;
            awaiting_ack = 1'b0;
        end
    endfunction

    // Advance the handover state by one event and collect the words it causes
    function automatic void predict_handover(t_op op, logic flag, logic [1:0] owner,
                                             logic [TIME_W-1:0] now);
        logic [1:0]        prev_owner;
        logic [TIME_W-1:0] age;
        run_kinds.delete();
        case (op)
            OP_VISIBILITY: begin
                heard_any = 1'b1;
                heard_ms = now;
                if (flag != disp_visible) begin
                    disp_visible = flag;
                    if (flag) yielded = 1'b0;
                    follow_wish();
                end
            end
            OP_SESSION: begin
                if (flag) begin
                    if (!session_active) begin
                        session_active = 1'b1;
                        follow_wish();
                    end
                end else begin
                    session_active = 1'b0;
                    holding = 1'b0;
                    awaiting_ack = 1'b0;
                    yielded = 1'b0;
                    owner_seen = OWNER_UNKNOWN;
                end
            end
            OP_OWNER: begin
                prev_owner = owner_seen;
                owner_seen = owner;
                if (en_handover && session_active) begin
                    if (owner == OWNER_ACCESSORY) begin
                        // partner confirms our take, or hands the screen back
                        if (awaiting_ack) begin
                            awaiting_ack = 1'b0;
                        end else if (!disp_visible && !holding &&
                                     prev_owner == OWNER_CONTROLLER) begin
                            holding = 1'b1;
                            yielded = 1'b0;
                            add_kind(KIND_RELEASED);
                        end
                    end else if (owner == OWNER_CONTROLLER) begin
                        // partner refuses our take, or claims the screen
                        if (awaiting_ack) begin
                            holding = 1'b0;
                            awaiting_ack = 1'b0;
                            yielded = 1'b1;
                        end else if (holding) begin
                            holding = 1'b0;
                            yielded = 1'b1;
                            if (!disp_visible) add_kind(KIND_REQUESTED);
                        end
                    end
                end
            end
            default: begin
                age = now - heard_ms;
                if (heard_any && !disp_visible && age > stale_limit) begin
                    disp_visible = 1'b1;
                    yielded = 1'b0;
                    follow_wish();
                end
            end
        endcase
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_ENABLE:  en_handover = value[0];
            CFG_UI_SHOW: en_ui_request = value[0];
            CFG_TIMEOUT: stale_limit = value;
            default: ;
        endcase
    endfunction

    // Compare one result word with the oldest expectation
    function automatic void check_word(logic [7:0] data, logic tlast);
        t_result_word want_word;
        if (expected_words.size() == 0) begin
            $error("unexpected word: result_kind %0d last_of_run %0b", data[2:0], tlast);
            mismatches++;
            return;
        end
        want_word = expected_words.pop_front();
        if (data[2:0] !== want_word.kind) begin
            $error("result_kind: expected %0d, got %0d", want_word.kind, data[2:0]);
            mismatches++;
        end
        if (tlast !== want_word.last) begin
            $error("last_of_run: expected %0b, got %0b", want_word.last, tlast);
            mismatches++;
        end
        if (data[7:3] !== 5'd0) begin
            $error("tdata padding: expected 0, got %0d", data[7:3]);
            mismatches++;
        end
    endfunction

    // Check output words, track register writes, predict accepted events
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) check_word(o_m_axis_tdata, o_m_axis_tlast);
            if (i_cfg_we) apply_reg(i_cfg_addr, i_cfg_wdata);
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_handover(t_op'(i_s_axis_tuser), i_s_axis_tdata[0],
                                 i_s_axis_tdata[2:1], i_s_axis_tdata[34:3]);
                if (row_typed) begin
                    run_kinds.delete();
                    if (row_n > 0) add_kind(row_k0);
                    if (row_n > 1) add_kind(row_k1);
                    if (row_n > 2) add_kind(row_k2);
                end
                foreach (run_kinds[i]) begin
                    add_word(run_kinds[i], (i == run_kinds.size() - 1));
                end
            end
        end
    end

    // Receiver: long hold-off on request, otherwise stall in random modes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
            hold_cnt <= hold_cnt + 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode <= $urandom_range(2);
                rx_mode_left <= $urandom_range(64, 8);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0: i_m_axis_tready <= 1'b1;
                1: i_m_axis_tready <= 1'($urandom_range(1));
                default: i_m_axis_tready <= ($urandom_range(3) == 0);
            endcase
        end
    end

    // Offer one event word and hold it until accepted; pace in bursts
    task automatic send_event(t_op op, logic flag, logic [1:0] owner, logic [TIME_W-1:0] stamp);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {5'd0, stamp, owner, flag};
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(40, 20) : $urandom_range(8);
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
    endtask

    // Mostly well-formed traffic on a running clock, some noise
    task automatic send_random_event();
        t_op               op;
        logic              flag;
        logic [1:0]        owner;
        logic [TIME_W-1:0] stamp;
        int                pick;
        pick = $urandom_range(99);
        flag = 1'($urandom_range(1));
        owner = 2'($urandom_range(3));
        stamp = $urandom();
        wall_ms += $urandom_range(400);
        if (pick < 8) begin
            op = t_op'($urandom_range(3));
        end else if (pick < 15) begin
            op = OP_SESSION;
            flag = ($urandom_range(3) != 0);
        end else if (pick < 45) begin
            op = OP_VISIBILITY;
            flag = ($urandom_range(3) == 0) ? disp_visible : !disp_visible;
            stamp = wall_ms;
        end else if (pick < 75) begin
            op = OP_OWNER;
            case ($urandom_range(9))
                0: owner = OWNER_NONE;
                1: owner = OWNER_UNKNOWN;
                2, 3, 4, 5: owner = OWNER_ACCESSORY;
                default: owner = OWNER_CONTROLLER;
            endcase
        end else begin
            op = OP_TICK;
            wall_ms += $urandom_range(3000);
            stamp = wall_ms;
        end
        send_event(op, flag, owner, stamp);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    task automatic load_regs(t_reg_set s);
        write_reg(CFG_ENABLE, CFG_DATA_W'(s.enable));
        write_reg(CFG_UI_SHOW, CFG_DATA_W'(s.ui_show));
        write_reg(CFG_TIMEOUT, s.timeout);
        write_reg(CFG_SPARE, $urandom());
        i_cfg_we <= 1'b0;
    endtask

    // Drop valid, wait out every expected word, then let the pipe settle
    task automatic drain_results();
        int waited;
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        for (waited = 0; waited < DRAIN_LIMIT && expected_words.size() != 0; waited++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        int   items;
        int   p;
        logic show_next;
        items = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at reset register values
        foreach (script[r]) begin
            row_typed <= script[r].typed;
            row_n     <= script[r].n;
            row_k0    <= script[r].k0;
            row_k1    <= script[r].k1;
            row_k2    <= script[r].k2;
            send_event(script[r].op, script[r].flag, script[r].owner, script[r].stamp);
            items++;
        end
        row_typed <= 1'b0;
        drain_results();

        for (p = 0; p < N_PHASES; p++) begin
            load_regs(phases[p]);
            if (p == 0) begin
                // hold the receiver off while visibility flips fill the run queue
                hold_req <= 1'b1;
                send_event(OP_SESSION, 1'b1, OWNER_NONE, $urandom());
                items++;
                show_next = !disp_visible;
                repeat (12) begin
                    wall_ms += $urandom_range(300);
                    send_event(OP_VISIBILITY, show_next, 2'($urandom_range(3)), wall_ms);
                    show_next = !show_next;
                    items++;
                end
            end
            repeat (PHASE_ITEMS) begin
                send_random_event();
                items++;
            end
            drain_results();
        end

        // finish the item budget at a mid timeout
        load_regs('{1'b1, 1'b1, 32'd1000});
        while (items < TOTAL_ITEMS) begin
            send_random_event();
            items++;
        end
        drain_results();

        if (expected_words.size() != 0) begin
            $error("%0d expected words never arrived", expected_words.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("screen_ownership_handover_fsm regression: pass");
        end else begin
            $display("screen_ownership_handover_fsm regression: fail");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #5_000_000;
        $display("screen_ownership_handover_fsm regression: fail");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/soh_pkg.sv
rtl/soh_front.sv
rtl/soh_fifo.sv
rtl/soh_back.sv
rtl/screen_ownership_handover_fsm.sv
dv/tb_screen_ownership_handover_fsm.sv
